>>> design/sto_pkg.sv
`timescale 1ns / 1ps
package sto_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int ID_W       = 4;
  localparam int DL_W       = 64;
  localparam int CH_W       = 16;
  localparam int SIG_W      = 32;
  localparam int DELAY_W    = 32;
  localparam int SCALE_W    = 10;
  localparam int PROD_W     = DELAY_W + SCALE_W;
  localparam int COUNT_W    = 5;
  localparam logic [SCALE_W-1:0] US_PER_MS = SCALE_W'(1000);

  localparam logic [1:0] OP_ARM    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] KIND_EXPIRED = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_NONE    = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [ID_W-1:0]   id;
    logic [DL_W-1:0]   dl;
    logic [CH_W-1:0]   ch;
    logic [SIG_W-1:0]  sig;
  } entry_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_POP,
    CMD_MARK,
    CMD_COMPACT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t        cmd;
    entry_t           new_e;
    logic [ID_W-1:0]  mark_id;
  } cell_ctrl_t;

endpackage

>>> design/sto_cell.sv
`timescale 1ns / 1ps
module sto_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  sto_pkg::cell_ctrl_t ctrl,
  input  sto_pkg::entry_t     prev_e,
  input  logic                prev_gt,
  input  logic                prev_hole,
  input  sto_pkg::entry_t     next_e,
  output sto_pkg::entry_t     cur_e,
  output logic                gt,
  output logic                hole,
  output logic                match
);
  import sto_pkg::*;

  entry_t e_r, e_nxt;
  logic   hole_r, hole_nxt;

  // empty cells count as later than any deadline so the insert point is found
  assign gt    = !e_r.valid || (e_r.dl > ctrl.new_e.dl);
  assign match = e_r.valid && (e_r.id == ctrl.mark_id);

  always_comb begin
    e_nxt    = e_r;
    hole_nxt = hole_r;
    unique case (ctrl.cmd)
      CMD_INSERT: begin
        if (gt) e_nxt = prev_gt ? prev_e : ctrl.new_e;
      end
      CMD_POP: e_nxt = next_e;
      CMD_MARK: hole_nxt = match;
      CMD_COMPACT: begin
        if (hole_r) begin
          e_nxt    = next_e;
          hole_nxt = 1'b0;
        end else if (prev_hole && e_r.valid) begin
          hole_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r.valid <= 1'b0;
      hole_r    <= 1'b0;
    end else begin
      e_r.valid <= e_nxt.valid;
      hole_r    <= hole_nxt;
    end
    e_r.id  <= e_nxt.id;
    e_r.dl  <= e_nxt.dl;
    e_r.ch  <= e_nxt.ch;
    e_r.sig <= e_nxt.sig;
  end

  assign cur_e = e_r;
  assign hole  = hole_r;

endmodule

>>> design/sorted_timeout_queue_top.sv
`timescale 1ns / 1ps
// Timer queue of sixteen slots kept in a row of cells sorted by deadline, earliest in the
// first cell. One transaction is taken at a time. A tick reports each due timer from the
// first cell as an expired result, or gives one nothing-due result. Cancel marks the slot;
// if it is armed, the gap left behind then moves one cell a cycle to the end of the
// occupied cells. Arm scales the delay, adds the deadline, takes out any old entry of the
// slot as a cancel does, and then inserts, which is done in all cells at once.
// Each result also waits for as long as the receiver holds off the output register. A result
// waits in the output register while the next transaction is accepted.
module sorted_timeout_queue_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // timer_id, delay_ms, channel_id, signal_value, now_us, zero fill
  input  logic [151:0] in_tdata,
  // opcode
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // expired_id, out_channel, out_signal, pending_count, zero fill
  output logic [63:0]  out_tdata,
  // kind
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);
  import sto_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MUL    = 7'b0000010,
    S_ADD    = 7'b0000100,
    S_REMOVE = 7'b0001000,
    S_INSERT = 7'b0010000,
    S_ACK    = 7'b0100000,
    S_TICK   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0]         op_r;
  logic [ID_W-1:0]    id_r;
  logic [DELAY_W-1:0] delay_r;
  logic [DL_W-1:0]    now_r;
  logic [CH_W-1:0]    ch_r;
  logic [SIG_W-1:0]   sig_r;
  logic [PROD_W-1:0]  prod_r;
  logic [DL_W-1:0]    new_dl_r, new_dl_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]    out_id_r, out_id_nxt;
  logic [CH_W-1:0]    out_ch_r, out_ch_nxt;
  logic [SIG_W-1:0]   out_sig_r, out_sig_nxt;
  logic [COUNT_W-1:0] out_pend_r, out_pend_nxt;
  logic               out_last_r, out_last_nxt;

  cell_ctrl_t ctrl;
  entry_t     cell_e [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] cell_gt, cell_hole, cell_match;

  logic           accept, out_free, any_match, any_hole, due0, due1;
  logic [DL_W:0]  sum;

  assign accept   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_tready;
  assign any_match = |cell_match;
  assign any_hole  = |cell_hole;
  assign due0 = cell_e[0].valid && (cell_e[0].dl <= now_r);
  assign due1 = cell_e[1].valid && (cell_e[1].dl <= now_r);
  assign sum  = {1'b0, now_r} + {{(DL_W+1-PROD_W){1'b0}}, prod_r};

  genvar g;
  generate
    for (g = 0; g < SLOT_COUNT; g++) begin : g_cell
      entry_t prev_e, next_e;
      logic   prev_gt, prev_hole;
      if (g == 0) begin : g_first
        assign prev_e    = '0;
        assign prev_gt   = 1'b0;
        assign prev_hole = 1'b0;
      end else begin : g_mid
        assign prev_e    = cell_e[g-1];
        assign prev_gt   = cell_gt[g-1];
        assign prev_hole = cell_hole[g-1];
      end
      if (g == SLOT_COUNT - 1) begin : g_last
        assign next_e = '0;
      end else begin : g_inner
        assign next_e = cell_e[g+1];
      end
      sto_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .prev_e    (prev_e),
        .prev_gt   (prev_gt),
        .prev_hole (prev_hole),
        .next_e    (next_e),
        .cur_e     (cell_e[g]),
        .gt        (cell_gt[g]),
        .hole      (cell_hole[g]),
        .match     (cell_match[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    new_dl_nxt    = new_dl_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_ch_nxt    = out_ch_r;
    out_sig_nxt   = out_sig_r;
    out_pend_nxt  = out_pend_r;
    out_last_nxt  = out_last_r;
    ctrl.cmd       = CMD_HOLD;
    ctrl.mark_id   = id_r;
    ctrl.new_e.valid = 1'b1;
    ctrl.new_e.id    = id_r;
    ctrl.new_e.dl    = new_dl_r;
    ctrl.new_e.ch    = ch_r;
    ctrl.new_e.sig   = sig_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_tuser)
            OP_ARM:    state_nxt = S_MUL;
            OP_CANCEL: state_nxt = S_ADD;
            OP_TICK:   state_nxt = S_TICK;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_MUL: state_nxt = S_ADD;
      S_ADD: begin
        ctrl.cmd   = CMD_MARK;
        new_dl_nxt = sum[DL_W] ? {DL_W{1'b1}} : sum[DL_W-1:0];
        if (any_match) begin
          count_nxt = count_r - COUNT_W'(1);
          state_nxt = S_REMOVE;
        end else begin
          state_nxt = (op_r == OP_ARM) ? S_INSERT : S_ACK;
        end
      end
      S_REMOVE: begin
        ctrl.cmd = CMD_COMPACT;
        if (!any_hole) state_nxt = (op_r == OP_ARM) ? S_INSERT : S_ACK;
      end
      S_INSERT: begin
        ctrl.cmd  = CMD_INSERT;
        count_nxt = count_r + COUNT_W'(1);
        state_nxt = S_ACK;
      end
      S_ACK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_ACK;
          out_id_nxt    = id_r;
          out_ch_nxt    = '0;
          out_sig_nxt   = '0;
          out_pend_nxt  = count_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_TICK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (due0) begin
            ctrl.cmd     = CMD_POP;
            count_nxt    = count_r - COUNT_W'(1);
            out_kind_nxt = KIND_EXPIRED;
            out_id_nxt   = cell_e[0].id;
            out_ch_nxt   = cell_e[0].ch;
            out_sig_nxt  = cell_e[0].sig;
            out_pend_nxt = count_r - COUNT_W'(1);
            out_last_nxt = !due1;
            if (!due1) state_nxt = S_IDLE;
          end else begin
            out_kind_nxt = KIND_NONE;
            out_id_nxt   = '0;
            out_ch_nxt   = '0;
            out_sig_nxt  = '0;
            out_pend_nxt = count_r;
            out_last_nxt = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (accept) begin
      op_r    <= in_tuser;
      id_r    <= in_tdata[3:0];
      delay_r <= in_tdata[35:4];
      ch_r    <= in_tdata[51:36];
      sig_r   <= in_tdata[83:52];
      now_r   <= in_tdata[147:84];
    end
    prod_r     <= delay_r * US_PER_MS;
    new_dl_r   <= new_dl_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_ch_r   <= out_ch_nxt;
    out_sig_r  <= out_sig_nxt;
    out_pend_r <= out_pend_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'b0, out_pend_r, out_sig_r, out_ch_r, out_id_r};

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(SLOT_COUNT))
    else $error("pending count beyond slot count");

  a_one_hole: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_hole) <= 1)
    else $error("more than one gap in the cell row");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK && out_free && due0) |=> count_r == $past(count_r) - COUNT_W'(1))
    else $error("expiry did not lower the pending count");

  a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INSERT) |-> !any_hole && !cell_e[SLOT_COUNT-1].valid)
    else $error("insert with no free cell");

endmodule
